### rtl/assert_macros.svh
// Assertion macros used by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`endif
`endif

### rtl/bpss_pkg.sv
// Constants, register indexes and helper functions of the bandpass sine saturation unit
`timescale 1ns / 1ps
package bpss_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_COEF_B0        = 3'd0;
    localparam logic [2:0] REG_COEF_A1        = 3'd1;
    localparam logic [2:0] REG_COEF_A2        = 3'd2;
    localparam logic [2:0] REG_BOOST_GAIN     = 3'd3;
    localparam logic [2:0] REG_INVERSE_BOOST  = 3'd4;
    localparam logic [2:0] REG_PHASE_OFFSET   = 3'd5;
    localparam logic [2:0] REG_SINE_OF_OFFSET = 3'd6;
    localparam logic [2:0] REG_WET_MIX        = 3'd7;

    // register reset values, truncated to the coefficient width where used
    localparam logic [63:0] COEF_B0_RESET        = 64'd676000000;
    localparam logic [63:0] COEF_A1_RESET        = -64'sd794000000;
    localparam logic [63:0] COEF_A2_RESET        = -64'sd279000000;
    localparam logic [24:0] BOOST_GAIN_RESET     = 25'd16777216;
    localparam logic [31:0] INVERSE_BOOST_RESET  = 32'd4194304;
    localparam logic [23:0] PHASE_OFFSET_RESET   = 24'd0;
    localparam logic [23:0] SINE_OF_OFFSET_RESET = 24'd0;
    localparam logic [16:0] WET_MIX_RESET        = 17'd65536;

    localparam logic [16:0] WET_FULL    = 17'd65536;
    localparam int          WET_FRAC    = 16;
    localparam logic [31:0] DITHER_SEED = 32'h2545F491;
    // 1/(2*pi) in Q0.32
    localparam logic [29:0] INV_TWO_PI  = 30'd683565276;
    localparam int          PHASE_LSB   = 22;
    localparam int          ARG_BITS    = 44;
    localparam int          ACC_BITS    = 34;
    localparam logic [2:0]  POLY_LAST   = 3'd4;

    // odd sine polynomial over a quarter wave, Q2.30, highest order first
    function automatic logic signed [ACC_BITS-1:0] sine_poly(input logic [2:0] idx);
        logic signed [ACC_BITS-1:0] c;
        case (idx)
            3'd0:    c = 34'sd172272;
            3'd1:    c = -34'sd5026995;
            3'd2:    c = 34'sd85569306;
            3'd3:    c = -34'sd693598668;
            3'd4:    c = 34'sd1686629713;
            default: c = '0;
        endcase
        return c;
    endfunction

    // advance the xorshift32 generator by one step
    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

### rtl/bandpass_sine_saturation_unit.sv
// Bandpass biquad with sine saturation, wet mix and LSB dither, on one bit-serial multiplier
// A new sample is accepted only in idle, after the last one has reached the output register.
// The shift-add multiplier takes one multiplier bit per cycle for each of fourteen products in turn.
// A finished sample waits in the output register while the next one is taken in.
// Reset (async, active low) loads the default registers, clears both delays, seeds the dither.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bandpass_sine_saturation_unit #(
    parameter int SAMPLE_BITS = bpss_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bpss_pkg::COEF_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0]                 in_sample,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]                 out_sample,
    input  logic                                          cfg_write,
    input  logic [2:0]                                    cfg_index,
    input  logic [((COEF_BITS > 32) ? COEF_BITS : 32)-1:0] cfg_data
);

    localparam int DB    = SAMPLE_BITS + 24;
    localparam int DB3   = DB + 3;
    localparam int DF    = SAMPLE_BITS + 15;
    localparam int OSH   = DF - (SAMPLE_BITS - 1);
    localparam int AW    = DB + 4;
    localparam int BW    = (COEF_BITS > 33) ? COEF_BITS : 33;
    localparam int PW    = AW + BW;
    localparam int PW1   = PW + 1;
    localparam int CNTW  = $clog2(BW + 1);
    localparam int ACCW  = bpss_pkg::ACC_BITS;
    localparam int ACCW1 = ACCW + 1;
    localparam int ARGW  = bpss_pkg::ARG_BITS;

    localparam int SH_XB0   = COEF_BITS - 18;
    localparam int SH_FA    = COEF_BITS - 2;
    localparam int SH_ARG   = DF;
    localparam int SH_POLY  = 30;
    localparam int SH_SHAPE = 39 - SAMPLE_BITS;
    localparam int SH_MIX   = bpss_pkg::WET_FRAC;

    localparam logic [PW-1:0] HALF_XB0    = (PW'(1) << SH_XB0) >> 1;
    localparam logic [PW-1:0] HALF_FA     = (PW'(1) << SH_FA) >> 1;
    localparam logic [PW-1:0] HALF_ARG    = (PW'(1) << SH_ARG) >> 1;
    localparam logic [PW-1:0] HALF_MIX    = (PW'(1) << SH_MIX) >> 1;
    localparam logic [PW-1:0] FLOOR_POLY  = (PW'(1) << SH_POLY) - PW'(1);
    localparam logic [PW-1:0] FLOOR_SHAPE = (PW'(1) << SH_SHAPE) - PW'(1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_SGN  = 3'd4;
    localparam logic [2:0] ST_NEXT = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // products in the order they are formed
    localparam logic [3:0] OP_XB0   = 4'd0;
    localparam logic [3:0] OP_FA1   = 4'd1;
    localparam logic [3:0] OP_FA2   = 4'd2;
    localparam logic [3:0] OP_ARG   = 4'd3;
    localparam logic [3:0] OP_PHASE = 4'd4;
    localparam logic [3:0] OP_U2    = 4'd5;
    localparam logic [3:0] OP_POLY  = 4'd6;
    localparam logic [3:0] OP_POLYU = 4'd7;
    localparam logic [3:0] OP_SHAPE = 4'd8;
    localparam logic [3:0] OP_MIXW  = 4'd9;
    localparam logic [3:0] OP_MIXD  = 4'd10;

    // configuration registers
    logic signed [COEF_BITS-1:0] coef_b0_reg, coef_a1_reg, coef_a2_reg;
    logic [24:0]                 boost_gain_reg;
    logic [31:0]                 inverse_boost_reg;
    logic signed [23:0]          phase_offset_reg, sine_of_offset_reg;
    logic [16:0]                 wet_mix_reg;

    // control and filter state
    logic [2:0]             state_reg, state_next;
    logic [3:0]             op_reg, op_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [2:0]             poly_idx_reg, poly_idx_next;
    logic signed [DB-1:0]   d1_reg, d1_next, d2_reg, d2_next;
    logic [31:0]            dither_reg, dither_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath registers
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic signed [DB-1:0]   xb0_reg, xb0_next, f_reg, f_next;
    logic signed [DB+1:0]   mix_reg, mix_next;
    logic [1:0]             quad_reg, quad_next;
    logic [30:0]            u_reg, u_next, u2_reg, u2_next;
    logic signed [AW-1:0]   opa_reg, opa_next;
    logic signed [BW-1:0]   opb_reg, opb_next;
    logic [PW-1:0]          mag_a_reg, mag_a_next;
    logic [BW-1:0]          mag_b_reg, mag_b_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    logic signed [PW:0]     res_reg, res_next;

    // combinational helpers
    logic [16:0]            wet_c;
    logic signed [AW-1:0]   xd_w;
    logic [AW-1:0]          opa_abs;
    logic [BW-1:0]          opb_abs;
    logic [CNTW-1:0]        op_len;
    logic [PW-1:0]          rnd_add, rnd_sum, rnd_val;
    logic                   flip;
    logic signed [PW:0]     sgn_val;
    logic signed [DB-1:0]   xb0_res;
    logic signed [DB+1:0]   res_db;
    logic signed [ACCW-1:0] res_acc, acc_sum;
    logic signed [ARGW-1:0] res_arg, arg_sum;
    logic signed [DB3-1:0]  f_sum, d1_sum, d2_sum, y_sum, o_sum, o_sh;
    logic signed [DB-1:0]   f_sat, y_sat;
    logic [31:0]            phase;
    logic [30:0]            u_val;
    logic signed [ACCW:0]   s_val;
    logic signed [SAMPLE_BITS-1:0] o_sat;

    // saturate a widened sum to the delay width
    function automatic logic signed [DB-1:0] sat_db(input logic signed [DB3-1:0] v);
        logic [3:0] top;
        logic signed [DB-1:0] r;
        top = v[DB3-1:DB-1];
        if ((&top) || !(|top))
        begin
            r = v[DB-1:0];
        end
        else if (v[DB3-1])
        begin
            r = {1'b1, {(DB-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DB-1){1'b1}}};
        end
        return r;
    endfunction

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    // operand preparation
    always_comb
    begin
        wet_c   = (wet_mix_reg > bpss_pkg::WET_FULL) ? bpss_pkg::WET_FULL : wet_mix_reg;
        xd_w    = AW'(x_reg) <<< OSH;
        opa_abs = opa_reg[AW-1] ? AW'(-opa_reg) : AW'(opa_reg);
        opb_abs = opb_reg[BW-1] ? BW'(-opb_reg) : BW'(opb_reg);
        case (op_reg)
            OP_XB0, OP_FA1, OP_FA2: op_len = CNTW'(COEF_BITS);
            OP_ARG:                 op_len = CNTW'(32);
            OP_PHASE:               op_len = CNTW'(30);
            OP_U2, OP_POLY, OP_POLYU: op_len = CNTW'(31);
            OP_SHAPE:               op_len = CNTW'(25);
            OP_MIXW, OP_MIXD:       op_len = CNTW'(17);
            default:                op_len = CNTW'(1);
        endcase
    end

    // rounding, scaling and sign of a finished product
    always_comb
    begin
        case (op_reg)
            OP_XB0:                   rnd_add = HALF_XB0;
            OP_FA1, OP_FA2:           rnd_add = HALF_FA;
            OP_ARG:                   rnd_add = HALF_ARG;
            OP_MIXW, OP_MIXD:         rnd_add = HALF_MIX;
            OP_U2, OP_POLY, OP_POLYU: rnd_add = neg_reg ? FLOOR_POLY : '0;
            OP_SHAPE:                 rnd_add = neg_reg ? FLOOR_SHAPE : '0;
            default:                  rnd_add = '0;
        endcase
        rnd_sum = prod_reg + rnd_add;
        case (op_reg)
            OP_XB0:                   rnd_val = rnd_sum >> SH_XB0;
            OP_FA1, OP_FA2:           rnd_val = rnd_sum >> SH_FA;
            OP_ARG:                   rnd_val = rnd_sum >> SH_ARG;
            OP_MIXW, OP_MIXD:         rnd_val = rnd_sum >> SH_MIX;
            OP_U2, OP_POLY, OP_POLYU: rnd_val = rnd_sum >> SH_POLY;
            OP_SHAPE:                 rnd_val = rnd_sum >> SH_SHAPE;
            default:                  rnd_val = rnd_sum;
        endcase
        // lower half of the wave negates the sine after its floor
        flip    = (op_reg == OP_POLYU) && quad_reg[1];
        sgn_val = (neg_reg ^ flip) ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    end

    // per-product arithmetic on the signed result
    always_comb
    begin
        xb0_res = res_reg[DB-1:0];
        res_db  = res_reg[DB+1:0];
        res_acc = res_reg[ACCW-1:0];
        res_arg = res_reg[ARGW-1:0];
        f_sum   = DB3'(xb0_res) + DB3'(d1_reg);
        d1_sum  = DB3'(d2_reg) - DB3'(res_db);
        d2_sum  = -DB3'(xb0_reg) - DB3'(res_db);
        y_sum   = DB3'(f_reg) + DB3'(res_db);
        f_sat   = sat_db(f_sum);
        y_sat   = sat_db(y_sum);
        arg_sum = res_arg + ARGW'(phase_offset_reg);
        phase   = res_reg[bpss_pkg::PHASE_LSB +: 32];
        u_val   = phase[30] ? ((31'd1 << 30) - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
        acc_sum = bpss_pkg::sine_poly(poly_idx_reg) + res_acc;
        s_val   = ACCW1'(res_acc) - ACCW1'($signed({sine_of_offset_reg, 8'h00}));
    end

    // dither, final shift and output saturation
    always_comb
    begin
        o_sum = DB3'(mix_reg) + DB3'({1'b0, dither_reg[31:32-OSH]});
        o_sh  = o_sum >>> OSH;
        if ((&o_sh[DB3-1:SAMPLE_BITS-1]) || !(|o_sh[DB3-1:SAMPLE_BITS-1]))
        begin
            o_sat = o_sh[SAMPLE_BITS-1:0];
        end
        else if (o_sh[DB3-1])
        begin
            o_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            o_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        poly_idx_next   = poly_idx_reg;
        d1_next         = d1_reg;
        d2_next         = d2_reg;
        dither_next     = dither_reg;
        out_valid_next  = out_valid_reg;
        x_next          = x_reg;
        out_sample_next = out_sample_reg;
        xb0_next        = xb0_reg;
        f_next          = f_reg;
        mix_next        = mix_reg;
        quad_next       = quad_reg;
        u_next          = u_reg;
        u2_next         = u2_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        mag_a_next      = mag_a_reg;
        mag_b_next      = mag_b_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        res_next        = res_reg;

        // drop the output once it is transferred
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = in_sample;
                    opa_next   = AW'(in_sample);
                    opb_next   = BW'(coef_b0_reg);
                    op_next    = OP_XB0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mag_a_next = PW'(opa_abs);
                mag_b_next = opb_abs;
                neg_next   = opa_reg[AW-1] ^ opb_reg[BW-1];
                prod_next  = '0;
                cnt_next   = op_len;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mag_b_reg[0])
                begin
                    prod_next = prod_reg + mag_a_reg;
                end
                mag_a_next = mag_a_reg << 1;
                mag_b_next = mag_b_reg >> 1;
                cnt_next   = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                prod_next  = rnd_val;
                state_next = ST_SGN;
            end
            ST_SGN:
            begin
                res_next   = sgn_val;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                state_next = ST_LOAD;
                case (op_reg)
                    OP_XB0:
                    begin
                        xb0_next = xb0_res;
                        f_next   = f_sat;
                        opa_next = AW'(f_sat);
                        opb_next = BW'(coef_a1_reg);
                        op_next  = OP_FA1;
                    end
                    OP_FA1:
                    begin
                        d1_next  = sat_db(d1_sum);
                        opa_next = AW'(f_reg);
                        opb_next = BW'(coef_a2_reg);
                        op_next  = OP_FA2;
                    end
                    OP_FA2:
                    begin
                        d2_next  = sat_db(d2_sum);
                        opa_next = xd_w - AW'(f_reg);
                        opb_next = BW'(inverse_boost_reg);
                        op_next  = OP_ARG;
                    end
                    OP_ARG:
                    begin
                        opa_next = AW'(arg_sum);
                        opb_next = BW'(bpss_pkg::INV_TWO_PI);
                        op_next  = OP_PHASE;
                    end
                    OP_PHASE:
                    begin
                        quad_next = phase[31:30];
                        u_next    = u_val;
                        opa_next  = AW'(u_val);
                        opb_next  = BW'(u_val);
                        op_next   = OP_U2;
                    end
                    OP_U2:
                    begin
                        u2_next       = res_reg[30:0];
                        poly_idx_next = 3'd1;
                        opa_next      = AW'(bpss_pkg::sine_poly(3'd0));
                        opb_next      = BW'(res_reg[30:0]);
                        op_next       = OP_POLY;
                    end
                    OP_POLY:
                    begin
                        opa_next = AW'(acc_sum);
                        if (poly_idx_reg == bpss_pkg::POLY_LAST)
                        begin
                            opb_next = BW'(u_reg);
                            op_next  = OP_POLYU;
                        end
                        else
                        begin
                            poly_idx_next = poly_idx_reg + 3'd1;
                            opb_next      = BW'(u2_reg);
                        end
                    end
                    OP_POLYU:
                    begin
                        opa_next = AW'(s_val);
                        opb_next = BW'(boost_gain_reg);
                        op_next  = OP_SHAPE;
                    end
                    OP_SHAPE:
                    begin
                        opa_next = AW'(y_sat);
                        opb_next = BW'(wet_c);
                        op_next  = OP_MIXW;
                    end
                    OP_MIXW:
                    begin
                        mix_next = res_db;
                        opa_next = xd_w;
                        opb_next = BW'(bpss_pkg::WET_FULL - wet_c);
                        op_next  = OP_MIXD;
                    end
                    OP_MIXD:
                    begin
                        mix_next    = mix_reg + res_db;
                        dither_next = bpss_pkg::xorshift32(dither_reg);
                        state_next  = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_sample_next = o_sat;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            op_reg             <= OP_XB0;
            cnt_reg            <= '0;
            poly_idx_reg       <= '0;
            d1_reg             <= '0;
            d2_reg             <= '0;
            dither_reg         <= bpss_pkg::DITHER_SEED;
            out_valid_reg      <= 1'b0;
            coef_b0_reg        <= COEF_BITS'(bpss_pkg::COEF_B0_RESET);
            coef_a1_reg        <= COEF_BITS'(bpss_pkg::COEF_A1_RESET);
            coef_a2_reg        <= COEF_BITS'(bpss_pkg::COEF_A2_RESET);
            boost_gain_reg     <= bpss_pkg::BOOST_GAIN_RESET;
            inverse_boost_reg  <= bpss_pkg::INVERSE_BOOST_RESET;
            phase_offset_reg   <= bpss_pkg::PHASE_OFFSET_RESET;
            sine_of_offset_reg <= bpss_pkg::SINE_OF_OFFSET_RESET;
            wet_mix_reg        <= bpss_pkg::WET_MIX_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            poly_idx_reg  <= poly_idx_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            dither_reg    <= dither_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    bpss_pkg::REG_COEF_B0:        coef_b0_reg <= cfg_data[COEF_BITS-1:0];
                    bpss_pkg::REG_COEF_A1:        coef_a1_reg <= cfg_data[COEF_BITS-1:0];
                    bpss_pkg::REG_COEF_A2:        coef_a2_reg <= cfg_data[COEF_BITS-1:0];
                    bpss_pkg::REG_BOOST_GAIN:     boost_gain_reg <= cfg_data[24:0];
                    bpss_pkg::REG_INVERSE_BOOST:  inverse_boost_reg <= cfg_data[31:0];
                    bpss_pkg::REG_PHASE_OFFSET:   phase_offset_reg <= cfg_data[23:0];
                    bpss_pkg::REG_SINE_OF_OFFSET: sine_of_offset_reg <= cfg_data[23:0];
                    bpss_pkg::REG_WET_MIX:        wet_mix_reg <= cfg_data[16:0];
                    default:                      ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        out_sample_reg <= out_sample_next;
        xb0_reg        <= xb0_next;
        f_reg          <= f_next;
        mix_reg        <= mix_next;
        quad_reg       <= quad_next;
        u_reg          <= u_next;
        u2_reg         <= u2_next;
        opa_reg        <= opa_next;
        opb_reg        <= opb_next;
        mag_a_reg      <= mag_a_next;
        mag_b_reg      <= mag_b_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        res_reg        <= res_next;
    end

    `ASSERT_IMPLY(a_mul_count, clk, rst_n, state_reg == ST_MUL, cnt_reg != '0, "multiplier ran out of count")
    `ASSERT_NEXT(a_accept_load, clk, rst_n, in_valid && in_ready, state_reg == ST_LOAD, "transfer did not start a product")
    `ASSERT_ALWAYS(a_dither_live, clk, rst_n, dither_reg != 32'h0, "dither generator stuck at zero")
    `ASSERT_NEXT(a_out_load, clk, rst_n, state_reg == ST_OUT && (!out_valid_reg || out_ready), out_valid_reg && state_reg == ST_IDLE, "result not loaded")

endmodule
